// File: hdl/vfp_pkg.sv
// vfp_pkg: shared types and constants of the video frame packetizer.
// No dependencies; imported by every module of the block.
package vfp_pkg;

   localparam int LEN_W     = 20;  // frame length and byte count width
   localparam int ADDR_W    = 20;  // frame base and read address port width
   localparam int PAY_OUT_W = 6;   // payload_bytes field width
   localparam int PKT_OUT_W = 7;   // packet_bytes field width

   localparam int          HEADER_BYTES = 2;
   localparam logic [7:0]  HDR_FID      = 8'h01;  // header frame-id bit
   localparam logic [7:0]  HDR_EOF      = 8'h02;  // header end-of-frame bit

   // one request transaction
   typedef struct packed {
      logic              frame0_ready;
      logic              frame1_ready;
      logic [ADDR_W-1:0] frame0_base;
      logic [LEN_W-1:0]  frame0_bytes;
      logic [ADDR_W-1:0] frame1_base;
      logic [LEN_W-1:0]  frame1_bytes;
      logic              ep_toggle;
   } req_type;

   // one packet descriptor
   typedef struct packed {
      logic                 fid_bit;
      logic                 eof_bit;
      logic [ADDR_W-1:0]    read_address;
      logic [PAY_OUT_W-1:0] payload_bytes;
      logic [PKT_OUT_W-1:0] packet_bytes;
      logic                 ping_buffer;
      logic                 frame_done;
      logic                 done_buffer;
   } rsp_type;

endpackage

// File: hdl/vfp_engine.sv
// vfp_engine: frame state registers and the single-pass packet computation.
// Depends on vfp_pkg.
module vfp_engine
   import vfp_pkg::*;
#(
   parameter int PACKET_BYTES = 64,
   parameter int ADDRESS_BITS = 20
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,        // the held request is consumed this cycle
   input  req_type req,
   output logic    has_result,  // request yields a descriptor
   output rsp_type rsp
);

   localparam int PAY_W = $clog2(PACKET_BYTES);
   localparam int KEEP_W = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << KEEP_W) - 64'd1);
   localparam logic [LEN_W-1:0] MAX_PAY = LEN_W'(PACKET_BYTES - HEADER_BYTES);

   logic [LEN_W-1:0] bytes_sent_ff, bytes_sent_in;
   logic             active_buffer_ff, active_buffer_in;
   logic             frame_id_ff, frame_id_in;

   logic              idle;
   logic              sel_buf;
   logic              fid;
   logic [ADDR_W-1:0] base;
   logic [LEN_W-1:0]  total;
   logic [LEN_W-1:0]  remaining;
   logic [PAY_W-1:0]  payload;
   logic [LEN_W-1:0]  pay_ext;
   logic [LEN_W-1:0]  pkt_sum;
   logic [ADDR_W-1:0] addr_sum;
   logic              last;

   always_comb begin
      idle       = (bytes_sent_ff == '0);
      has_result = !idle || req.frame0_ready || req.frame1_ready;
      sel_buf    = idle ? !req.frame0_ready : active_buffer_ff;
      fid        = idle ? (frame_id_ff ^ HDR_FID[0]) : frame_id_ff;
      base       = sel_buf ? req.frame1_base  : req.frame0_base;
      total      = sel_buf ? req.frame1_bytes : req.frame0_bytes;
      // length may shrink under a running frame: saturate at zero
      remaining  = (total > bytes_sent_ff) ? (total - bytes_sent_ff) : '0;
      last       = (remaining <= MAX_PAY);
      payload    = last ? PAY_W'(remaining) : PAY_W'(MAX_PAY);
      pay_ext    = LEN_W'(payload);
      pkt_sum    = pay_ext + LEN_W'(HEADER_BYTES);
      addr_sum   = (base + ADDR_W'(bytes_sent_ff)) & ADDR_MASK;

      rsp.fid_bit       = fid;
      rsp.eof_bit       = last & HDR_EOF[1];
      rsp.read_address  = addr_sum;
      rsp.payload_bytes = pay_ext[PAY_OUT_W-1:0];
      rsp.packet_bytes  = pkt_sum[PKT_OUT_W-1:0];
      rsp.ping_buffer   = !req.ep_toggle;
      rsp.frame_done    = last;
      rsp.done_buffer   = last & sel_buf;

      bytes_sent_in    = bytes_sent_ff;
      active_buffer_in = active_buffer_ff;
      frame_id_in      = frame_id_ff;
      if (step && has_result) begin
         bytes_sent_in    = last ? '0 : (bytes_sent_ff + pay_ext);
         active_buffer_in = sel_buf;
         frame_id_in      = fid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_sent_ff    <= '0;
         active_buffer_ff <= 1'b0;
         frame_id_ff      <= 1'b1;
      end else begin
         bytes_sent_ff    <= bytes_sent_in;
         active_buffer_ff <= active_buffer_in;
         frame_id_ff      <= frame_id_in;
      end
   end

endmodule

// File: hdl/vfp_out_reg.sv
// vfp_out_reg: result register with valid/ready toward the consumer.
// Depends on vfp_pkg.
module vfp_out_reg
   import vfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,       // new descriptor arrives
   input  rsp_type data_in,
   output logic    room,       // register can take a descriptor this cycle
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type data_out
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in_nxt;

   always_comb begin
      room        = !valid_ff || out_ready;
      valid_in    = valid_ff;
      data_in_nxt = data_ff;
      if (room) begin
         valid_in    = load;
         data_in_nxt = data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in_nxt;
   end

   assign out_valid = valid_ff;
   assign data_out  = data_ff;

endmodule

// File: hdl/video_frame_packetizer_core.sv
// video_frame_packetizer_core: top level of the video payload packetizer.
// Depends on vfp_pkg, vfp_engine and vfp_out_reg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_valid / req_ready | frame ready flags, bases,
//           |           |                       | lengths, endpoint toggle
//   rsp     | out       | rsp_valid / rsp_ready | header bits, address, lengths,
//           |           |                       | ping buffer, frame release
//
// One transaction per cycle sustained while rsp is not stalled; a request
// passes the input register, then the result register.
// A request with no frame running and no buffer ready produces no response.
// Synchronous active-high reset empties both registers and sets frame id to 1.
// A stalled rsp holds its data; the input register keeps taking a new
// request whenever its held one moves on in the same cycle.
module video_frame_packetizer_core
   import vfp_pkg::*;
#(
   parameter int PACKET_BYTES = 64,
   parameter int ADDRESS_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_frame0_ready,
   input  logic                 req_frame1_ready,
   input  logic [ADDR_W-1:0]    req_frame0_base,
   input  logic [LEN_W-1:0]     req_frame0_bytes,
   input  logic [ADDR_W-1:0]    req_frame1_base,
   input  logic [LEN_W-1:0]     req_frame1_bytes,
   input  logic                 req_ep_toggle,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_fid_bit,
   output logic                 rsp_eof_bit,
   output logic [ADDR_W-1:0]    rsp_read_address,
   output logic [PAY_OUT_W-1:0] rsp_payload_bytes,
   output logic [PKT_OUT_W-1:0] rsp_packet_bytes,
   output logic                 rsp_ping_buffer,
   output logic                 rsp_frame_done,
   output logic                 rsp_done_buffer
);

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   req_type req_bus;

   logic    step;        // held request is processed this cycle
   logic    has_result;
   logic    room;
   rsp_type calc_rsp;
   rsp_type out_rsp;

   assign req_bus = '{
      frame0_ready: req_frame0_ready,
      frame1_ready: req_frame1_ready,
      frame0_base:  req_frame0_base,
      frame0_bytes: req_frame0_bytes,
      frame1_base:  req_frame1_base,
      frame1_bytes: req_frame1_bytes,
      ep_toggle:    req_ep_toggle
   };

   // held request moves when the result register has room (dropped requests
   // need no room but waiting keeps the order simple and costs nothing)
   assign step      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_data_in  = req_bus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   vfp_engine #(
      .PACKET_BYTES (PACKET_BYTES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .req        (in_data_ff),
      .has_result (has_result),
      .rsp        (calc_rsp)
   );

   vfp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step && has_result),
      .data_in   (calc_rsp),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .data_out  (out_rsp)
   );

   assign rsp_fid_bit       = out_rsp.fid_bit;
   assign rsp_eof_bit       = out_rsp.eof_bit;
   assign rsp_read_address  = out_rsp.read_address;
   assign rsp_payload_bytes = out_rsp.payload_bytes;
   assign rsp_packet_bytes  = out_rsp.packet_bytes;
   assign rsp_ping_buffer   = out_rsp.ping_buffer;
   assign rsp_frame_done    = out_rsp.frame_done;
   assign rsp_done_buffer   = out_rsp.done_buffer;

`ifndef ASSERT_OFF
   // a stalled response blocks the held request
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && in_valid_ff |=> in_valid_ff)
      else $error("request left input register while response stalled");

   // release index only meaningful on the last packet
   a_done_buffer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> !rsp_done_buffer)
      else $error("done_buffer set without frame_done");

   // end-of-frame header bit and buffer release go together
   a_eof_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_eof_bit == rsp_frame_done))
      else $error("eof_bit and frame_done disagree");
`endif

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for video_frame_packetizer_core.
// Depends on vfp_pkg and the packetizer RTL; a queue-fed driver, a stalling
// response sink and a packet predictor check every descriptor in order.
`timescale 1ns / 1ps

module tb;
   import vfp_pkg::*;

   localparam int PKT_BYTES   = 64;
   localparam int MAX_PAYLOAD = PKT_BYTES - HEADER_BYTES;
   localparam int RANDOM_REQS = 400;
   localparam int IDLE_LIMIT  = 1000;  // cycles with no transaction on either side
   localparam int DRAIN       = 8;     // settling time after the last check

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_frame0_ready = 1'b0;
   logic                 req_frame1_ready = 1'b0;
   logic [ADDR_W-1:0]    req_frame0_base = '0;
   logic [LEN_W-1:0]     req_frame0_bytes = '0;
   logic [ADDR_W-1:0]    req_frame1_base = '0;
   logic [LEN_W-1:0]     req_frame1_bytes = '0;
   logic                 req_ep_toggle = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_fid_bit;
   logic                 rsp_eof_bit;
   logic [ADDR_W-1:0]    rsp_read_address;
   logic [PAY_OUT_W-1:0] rsp_payload_bytes;
   logic [PKT_OUT_W-1:0] rsp_packet_bytes;
   logic                 rsp_ping_buffer;
   logic                 rsp_frame_done;
   logic                 rsp_done_buffer;

   video_frame_packetizer_core #(
      .PACKET_BYTES (PKT_BYTES),
      .ADDRESS_BITS (ADDR_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame0_ready  (req_frame0_ready),
      .req_frame1_ready  (req_frame1_ready),
      .req_frame0_base   (req_frame0_base),
      .req_frame0_bytes  (req_frame0_bytes),
      .req_frame1_base   (req_frame1_base),
      .req_frame1_bytes  (req_frame1_bytes),
      .req_ep_toggle     (req_ep_toggle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fid_bit       (rsp_fid_bit),
      .rsp_eof_bit       (rsp_eof_bit),
      .rsp_read_address  (rsp_read_address),
      .rsp_payload_bytes (rsp_payload_bytes),
      .rsp_packet_bytes  (rsp_packet_bytes),
      .rsp_ping_buffer   (rsp_ping_buffer),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_done_buffer   (rsp_done_buffer)
   );

   always #4 clock = ~clock;

   req_type request_queue[$];  // requests still to be driven
   rsp_type packet_queue[$];   // predicted descriptors, oldest first
   req_type cur_req;
   rsp_type oldest;

   // predictor state: mirrors the block's frame progress
   logic [LEN_W-1:0] sent_bytes = '0;
   logic             cur_buffer = 1'b0;
   logic             cur_fid    = 1'b1;

   int  total_reqs = 0;
   int  accepted_reqs = 0;
   int  silent_reqs = 0;
   int  predicted_packets = 0;
   int  checked_packets = 0;
   int  frames_closed = 0;
   int  errors = 0;
   int  idle_cycles = 0;
   bit  req_taken = 1'b0;
   int  gap_left = 0;
   int  burst_left = 1;
   int  stall_left = 0;
   int  rx_cycle = 0;
   int  rx_mode = 0;

   task automatic add_req(input bit r0, input bit r1,
                          input logic [ADDR_W-1:0] b0, input logic [LEN_W-1:0] l0,
                          input logic [ADDR_W-1:0] b1, input logic [LEN_W-1:0] l1,
                          input bit tog);
      req_type r;
      r.frame0_ready = r0;
      r.frame1_ready = r1;
      r.frame0_base  = b0;
      r.frame0_bytes = l0;
      r.frame1_base  = b1;
      r.frame1_bytes = l1;
      r.ep_toggle    = tog;
      request_queue.push_back(r);
   endtask

   function automatic int frame_length();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return MAX_PAYLOAD * $urandom_range(1, 4);  // exact fit
         2:       return $urandom_range(1, MAX_PAYLOAD - 1);  // single packet
         3:       return $urandom_range(500, 2500);
         default: return $urandom_range(0, 300);
      endcase
   endfunction

   // Works out the descriptor for one accepted request and advances the frame.
   task automatic packetize(input req_type r);
      logic [ADDR_W-1:0] base;
      logic [LEN_W-1:0]  total;
      logic [LEN_W-1:0]  left;
      logic [LEN_W-1:0]  pay;
      bit                last;
      rsp_type           p;
      if (sent_bytes == '0) begin
         if (r.frame0_ready) begin
            cur_buffer = 1'b0;
         end else if (r.frame1_ready) begin
            cur_buffer = 1'b1;
         end else begin
            silent_reqs++;
            return;
         end
         cur_fid = ~cur_fid;
      end
      base  = cur_buffer ? r.frame1_base  : r.frame0_base;
      total = cur_buffer ? r.frame1_bytes : r.frame0_bytes;
      left  = (total > sent_bytes) ? total - sent_bytes : '0;
      pay   = (left < MAX_PAYLOAD) ? left : LEN_W'(MAX_PAYLOAD);
      last  = (pay == left);
      p.fid_bit       = cur_fid;
      p.eof_bit       = last;
      p.read_address  = base + sent_bytes;  // wraps at the address width
      p.payload_bytes = pay[PAY_OUT_W-1:0];
      p.packet_bytes  = PKT_OUT_W'(pay + HEADER_BYTES);
      p.ping_buffer   = ~r.ep_toggle;
      p.frame_done    = last;
      p.done_buffer   = last & cur_buffer;
      packet_queue.push_back(p);
      predicted_packets++;
      if (last) begin
         sent_bytes = '0;
         frames_closed++;
      end else begin
         sent_bytes = sent_bytes + pay;
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0 || request_queue.size() == 0) begin
            if (gap_left > 0) gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else begin
            cur_req = request_queue.pop_front();
            req_valid        <= 1'b1;
            req_frame0_ready <= cur_req.frame0_ready;
            req_frame1_ready <= cur_req.frame1_ready;
            req_frame0_base  <= cur_req.frame0_base;
            req_frame0_bytes <= cur_req.frame0_bytes;
            req_frame1_base  <= cur_req.frame1_base;
            req_frame1_bytes <= cur_req.frame1_bytes;
            req_ep_toggle    <= cur_req.ep_toggle;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
      end
   end

   // Response sink: always ready, random stalls or a fixed pattern, mode picked at random.
   always @(negedge clock) begin
      rx_cycle = rx_cycle + 1;
      if (rx_cycle % 100 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: begin
            if (stall_left > 0) begin
               stall_left = stall_left - 1;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
               stall_left = $urandom_range(0, 11);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
         default: rsp_ready <= (rx_cycle % 5 != 0) && (rx_cycle % 7 != 3);
      endcase
   end

   // Monitor: responses are checked before this edge's request is predicted,
   // so a same-cycle transaction never matches its own prediction.
   always @(posedge clock) begin
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (packet_queue.size() == 0) begin
               $error("response with no prediction pending (address %0h)",
                      rsp_read_address);
               errors++;
            end else begin
               oldest = packet_queue.pop_front();
               check_field("fid_bit",       32'(oldest.fid_bit),       32'(rsp_fid_bit));
               check_field("eof_bit",       32'(oldest.eof_bit),       32'(rsp_eof_bit));
               check_field("read_address",  32'(oldest.read_address),
                           32'(rsp_read_address));
               check_field("payload_bytes", 32'(oldest.payload_bytes),
                           32'(rsp_payload_bytes));
               check_field("packet_bytes",  32'(oldest.packet_bytes),
                           32'(rsp_packet_bytes));
               check_field("ping_buffer",   32'(oldest.ping_buffer),   32'(rsp_ping_buffer));
               check_field("frame_done",    32'(oldest.frame_done),    32'(rsp_frame_done));
               check_field("done_buffer",   32'(oldest.done_buffer),   32'(rsp_done_buffer));
               checked_packets++;
            end
         end
         if (req_valid && req_ready) begin
            packetize('{frame0_ready: req_frame0_ready, frame1_ready: req_frame1_ready,
                        frame0_base: req_frame0_base, frame0_bytes: req_frame0_bytes,
                        frame1_base: req_frame1_base, frame1_bytes: req_frame1_bytes,
                        ep_toggle: req_ep_toggle});
            accepted_reqs++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $error("timeout: no transaction for %0d cycles, %0d responses outstanding",
             IDLE_LIMIT, predicted_packets - checked_packets);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int               gen_count;
      bit               r0;
      bit               r1;
      int               act;
      int               sent;
      int               left;
      int               pay;
      bit               done;
      logic [ADDR_W-1:0] bases[2];
      logic [LEN_W-1:0]  lens[2];

      // directed: nothing ready, empty frame, one-packet frame on buffer 1
      add_req(0, 0, 20'h00000, 20'h00000, 20'h00000, 20'h00000, 0);
      add_req(1, 0, 20'h00100, 20'h00000, 20'h00200, 20'h00005, 1);
      add_req(0, 1, 20'h00100, 20'h00007, 20'h00200, 20'h0000A, 0);
      // both ready picks buffer 0; exact fits of one and two packets
      add_req(1, 1, 20'h01000, 20'd62,    20'h02000, 20'd30,    1);
      add_req(1, 0, 20'h03000, 20'd124,   20'h00000, 20'd0,     0);
      add_req(1, 0, 20'h03000, 20'd124,   20'h00000, 20'd0,     1);
      // one byte past a full packet
      add_req(1, 1, 20'h04000, 20'd63,    20'h05000, 20'd99,    0);
      add_req(1, 1, 20'h04000, 20'd63,    20'h05000, 20'd99,    1);
      // ready flags change mid-frame; buffer 1 keeps going
      add_req(0, 1, 20'h00000, 20'd10,    20'h06000, 20'd150,   0);
      add_req(1, 0, 20'h00000, 20'd10,    20'h06000, 20'd150,   1);
      add_req(0, 0, 20'h00000, 20'd10,    20'h06000, 20'd150,   0);
      // length shrinks below bytes already sent
      add_req(1, 0, 20'h07000, 20'd200,   20'h00000, 20'd0,     1);
      add_req(1, 0, 20'h07000, 20'd10,    20'h00000, 20'd0,     0);
      // read address wraps
      add_req(1, 0, 20'hFFFF0, 20'd100,   20'h00000, 20'd0,     1);
      add_req(1, 0, 20'hFFFF0, 20'd100,   20'h00000, 20'd0,     0);
      // all-ones fields, then the frame is cut off
      add_req(1, 1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1);
      add_req(1, 1, 20'hFFFFF, 20'h00000, 20'hFFFFF, 20'h00000, 0);
      add_req(0, 0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1);

      gen_count = 0;
      while (gen_count < RANDOM_REQS) begin
         if ($urandom_range(0, 4) != 0) begin
            // whole frame, lengths held on the active buffer
            r0 = 1'($urandom_range(0, 1));
            r1 = r0 ? 1'($urandom_range(0, 1)) : 1'b1;
            act = r0 ? 0 : 1;
            bases[0] = ADDR_W'($urandom_range(0, 20'hFFFFF));
            bases[1] = ADDR_W'($urandom_range(0, 20'hFFFFF));
            lens[0]  = LEN_W'(frame_length());
            lens[1]  = LEN_W'(frame_length());
            sent = 0;
            done = 1'b0;
            while (!done) begin
               if (sent > 0 && $urandom_range(0, 15) == 0) begin
                  lens[act] = LEN_W'($urandom_range(0, sent));
                  done = 1'b1;
               end else begin
                  left = lens[act] - sent;
                  pay  = (left < MAX_PAYLOAD) ? left : MAX_PAYLOAD;
                  if (pay == left) done = 1'b1;
                  else sent = sent + pay;
               end
               add_req(r0, r1, bases[0], lens[0], bases[1], lens[1],
                       1'($urandom_range(0, 1)));
               gen_count++;
               // only the active buffer matters once the frame runs
               r0 = 1'($urandom_range(0, 1));
               r1 = 1'($urandom_range(0, 1));
               bases[1-act] = ADDR_W'($urandom_range(0, 20'hFFFFF));
               lens[1-act]  = LEN_W'($urandom_range(0, 20'hFFFFF));
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               add_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       ADDR_W'($urandom_range(0, 20'hFFFFF)),
                       LEN_W'($urandom_range(0, 20'hFFFFF)),
                       ADDR_W'($urandom_range(0, 20'hFFFFF)),
                       LEN_W'($urandom_range(0, 20'hFFFFF)),
                       1'($urandom_range(0, 1)));
               gen_count++;
            end
            // zero lengths close whatever frame the noise left open
            add_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    ADDR_W'($urandom_range(0, 20'hFFFFF)), 20'h00000,
                    ADDR_W'($urandom_range(0, 20'hFFFFF)), 20'h00000,
                    1'($urandom_range(0, 1)));
         end
      end
      total_reqs = request_queue.size();

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      wait (accepted_reqs == total_reqs && checked_packets == predicted_packets);
      repeat (DRAIN) @(posedge clock);

      $display("run covered %0d requests (%0d with no packet), %0d descriptors checked",
               accepted_reqs, silent_reqs, checked_packets);
      $display("%0d frames closed, %0d mismatches", frames_closed, errors);
      if (errors == 0 && checked_packets == predicted_packets) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
